FILE: rtl/fgn_pkg.sv
// ----------------------------------------------------------------------------
// fgn_pkg: shared types, constants and gradient table
// Formats, hash constants, configuration record, octave bus and the
// cosine/sine table built at elaboration.
// ----------------------------------------------------------------------------
package fgn_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int ANGLE_BITS      = 10;
  localparam int FRAC_BITS       = 16;

  // widths: Q30 noise, amplitude, weighted sum, amplitude sum, quotient, divider remainder
  localparam int N_W    = 36;
  localparam int AMP_W  = 17;
  localparam int SUM_W  = 58;
  localparam int NORM_W = 21;
  localparam int Q_W    = 33;
  localparam int RW     = NORM_W + Q_W;

  localparam int OCT_STAGES = 13;

  localparam logic [31:0] H_MX = 32'h9e3779b1;
  localparam logic [31:0] H_MY = 32'h85ebca77;
  localparam logic [31:0] H_MS = 32'hc2b2ae3d;
  localparam logic [31:0] H_M1 = 32'h7feb352d;
  localparam logic [31:0] H_M2 = 32'h846ca68b;

  localparam logic signed [31:0] SQRT2_Q30 = 32'sd1518500250;
  localparam logic [30:0]        ONE_Q30   = 31'h4000_0000;
  localparam longint unsigned    TWO_PI_Q30 = 64'd6746518852;

  localparam logic [31:0] FREQ_ONE = 32'h0001_0000;
  localparam logic [16:0] AMP_ONE  = 17'h1_0000;

  // register map (word index)
  localparam logic [2:0] REG_SEED    = 3'd0;
  localparam logic [2:0] REG_OCTAVES = 3'd1;
  localparam logic [2:0] REG_LACUN   = 3'd2;
  localparam logic [2:0] REG_GAIN    = 3'd3;
  localparam logic [2:0] REG_RIDGED  = 3'd4;

  typedef struct packed {
    logic [31:0] seed;
    logic [3:0]  octave_count;
    logic [15:0] lacunarity;
    logic [15:0] gain;
    logic        ridged_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0]       x;
    logic signed [31:0]       y;
    logic [31:0]              freq;
    logic [AMP_W-1:0]         amp;
    logic signed [SUM_W-1:0]  sum;
    logic [NORM_W-1:0]        norm;
  } oct_bus_t;

  // half a quadrant of angles, both ends included
  localparam int GRAD_N = (1 << (ANGLE_BITS - 3)) + 1;

  typedef logic [31:0] grad_lut_t [GRAD_N];

  // {cos, sin} rounded to Q15, from truncated Q30 Taylor series
  function automatic grad_lut_t build_grad_lut();
    grad_lut_t lut;
    longint unsigned x, x2, x3, x4, x5, x6, x7, x8, s, c;
    for (int r = 0; r < GRAD_N; r++) begin
      x  = (longint'(r) * TWO_PI_Q30) >> ANGLE_BITS;
      x2 = (x * x) >> 30;
      x3 = (x2 * x) >> 30;
      x4 = (x2 * x2) >> 30;
      x5 = (x4 * x) >> 30;
      x6 = (x4 * x2) >> 30;
      x7 = (x6 * x) >> 30;
      x8 = (x4 * x4) >> 30;
      s  = (x + x5 / 120) - (x3 / 6 + x7 / 5040);
      c  = (64'd1073741824 + x4 / 24 + x8 / 40320) - (x2 / 2 + x6 / 720);
      lut[r] = {16'((c + 64'd16384) >> 15), 16'((s + 64'd16384) >> 15)};
    end
    return lut;
  endfunction

  localparam grad_lut_t GRAD_LUT = build_grad_lut();

  // unit gradient {gx, gy}, signed Q15, for an angle index
  function automatic logic [33:0] grad_vec(logic [ANGLE_BITS-1:0] a);
    logic [1:0]              quad;
    logic [ANGLE_BITS-3:0]   r;
    logic [ANGLE_BITS-3:0]   idx;
    logic                    swap;
    logic [31:0]             e;
    logic signed [16:0]      cr, sr, gx, gy;
    quad = a[ANGLE_BITS-1 -: 2];
    r    = a[ANGLE_BITS-3:0];
    swap = r > (ANGLE_BITS-2)'(GRAD_N - 1);
    idx  = swap ? (~r + 1'b1) : r;
    e    = GRAD_LUT[idx];
    cr   = swap ? $signed({1'b0, e[15:0]})  : $signed({1'b0, e[31:16]});
    sr   = swap ? $signed({1'b0, e[31:16]}) : $signed({1'b0, e[15:0]});
    case (quad)
      2'd0: begin
        gx = cr;  gy = sr;
      end
      2'd1: begin
        gx = -sr; gy = cr;
      end
      2'd2: begin
        gx = -cr; gy = -sr;
      end
      default: begin
        gx = sr;  gy = -cr;
      end
    endcase
    return {gx, gy};
  endfunction

endpackage

FILE: rtl/fractal_gradient_noise_2d.sv
// ----------------------------------------------------------------------------
// fractal_gradient_noise_2d: 2D gradient noise, one point per cycle unless held
// Octave chain of gradient noise units followed by a normalising divider.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (in_valid/in_ready): one point per beat, x and y signed Q16.16.
//   Result channel (out_valid/out_ready): one noise value per beat, signed
//   Q1.15, saturated. Results leave in the order the points came in.
//   Config port: APB-style, registers at byte offsets 0 seed, 4 octave count,
//   8 lacunarity, 12 gain, 16 ridged mode. Write only while no point is in
//   flight. pready is tied high; reads return the stored value.
// Throughput: one beat per cycle while out_ready does not hold the pipeline.
// Pipeline: octave units of 13 stages each, then the divider with 33
//   quotient stages plus sign and rounding stages.
//   All MAX_OCTAVES stages are always walked; octaves above the programmed
//   count just leave the sums unchanged, so latency does not follow the count.
// Reset: valid bits clear, registers return to seed 0, one octave,
//   lacunarity 2.0, gain 0.5, fbm mode.
// Stall: the whole pipeline holds while a result waits and out_ready is low;
//   in_ready drops in the same cycle, nothing is lost or repeated.
// ----------------------------------------------------------------------------
module fractal_gradient_noise_2d #(
  parameter int MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // input beats
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_x_coord,
  input  logic signed [31:0]  in_y_coord,
  // result beats
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_noise_value,
  // configuration
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  fgn_pkg::cfg_t      cfg;
  fgn_pkg::oct_bus_t  bus   [MAX_OCTAVES+1];
  logic               vld   [MAX_OCTAVES+1];
  logic [4:0]         octs;
  logic [MAX_OCTAVES-1:0] active;
  logic               adv;
  logic               res_valid;

  // whole pipeline steps when the result register is free or being taken
  assign adv       = !res_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = res_valid;

  fgn_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // octave count: zero acts as one, anything above the chain length clamps
  always_comb begin
    if (cfg.octave_count == 4'd0) begin
      octs = 5'd1;
    end else if ({1'b0, cfg.octave_count} > 5'(MAX_OCTAVES)) begin
      octs = 5'(MAX_OCTAVES);
    end else begin
      octs = {1'b0, cfg.octave_count};
    end
  end

  // first octave starts at frequency 1.0 and amplitude 1.0
  always_comb begin
    vld[0]      = in_valid;
    bus[0].x    = in_x_coord;
    bus[0].y    = in_y_coord;
    bus[0].freq = fgn_pkg::FREQ_ONE;
    bus[0].amp  = fgn_pkg::AMP_ONE;
    bus[0].sum  = '0;
    bus[0].norm = '0;
  end

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    assign active[k] = octs > 5'(k);
    fgn_octave u_oct (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .cfg       (cfg),
      .active    (active[k]),
      .in_valid  (vld[k]),
      .in_bus    (bus[k]),
      .out_valid (vld[k+1]),
      .out_bus   (bus[k+1])
    );
  end

  fgn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (vld[MAX_OCTAVES]),
    .in_sum    (bus[MAX_OCTAVES].sum),
    .in_norm   (bus[MAX_OCTAVES].norm),
    .out_valid (res_valid),
    .out_value (out_noise_value)
  );

endmodule

FILE: rtl/fgn_cfg.sv
// ----------------------------------------------------------------------------
// fgn_cfg: configuration registers
// APB-style register file; writes in the access phase, reads muxed.
// ----------------------------------------------------------------------------
module fgn_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output fgn_pkg::cfg_t       cfg
);

  fgn_pkg::cfg_t cfg_r;
  logic [2:0]    idx;
  logic          wr;

  assign idx        = cfg_paddr[4:2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed         <= 32'd0;
      cfg_r.octave_count <= 4'd1;
      cfg_r.lacunarity   <= 16'd8192;
      cfg_r.gain         <= 16'd32768;
      cfg_r.ridged_mode  <= 1'b0;
    end else if (wr) begin
      case (idx)
        fgn_pkg::REG_SEED:    cfg_r.seed         <= cfg_pwdata;
        fgn_pkg::REG_OCTAVES: cfg_r.octave_count <= cfg_pwdata[3:0];
        fgn_pkg::REG_LACUN:   cfg_r.lacunarity   <= cfg_pwdata[15:0];
        fgn_pkg::REG_GAIN:    cfg_r.gain         <= cfg_pwdata[15:0];
        fgn_pkg::REG_RIDGED:  cfg_r.ridged_mode  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fgn_pkg::REG_SEED:    cfg_prdata = cfg_r.seed;
      fgn_pkg::REG_OCTAVES: cfg_prdata = {28'd0, cfg_r.octave_count};
      fgn_pkg::REG_LACUN:   cfg_prdata = {16'd0, cfg_r.lacunarity};
      fgn_pkg::REG_GAIN:    cfg_prdata = {16'd0, cfg_r.gain};
      fgn_pkg::REG_RIDGED:  cfg_prdata = {31'd0, cfg_r.ridged_mode};
      default:              cfg_prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/fgn_octave.sv
// ----------------------------------------------------------------------------
// fgn_octave: one octave of gradient noise
// 13 register stages: scale, cell/fraction, corner hash, gradient lookup,
// dot products, fade blends, sqrt2 scale, ridge shaping, weighted accumulate.
// ----------------------------------------------------------------------------
module fgn_octave (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  fgn_pkg::cfg_t       cfg,
  input  logic                active,
  input  logic                in_valid,
  input  fgn_pkg::oct_bus_t   in_bus,
  output logic                out_valid,
  output fgn_pkg::oct_bus_t   out_bus
);

  localparam int NS  = fgn_pkg::OCT_STAGES;
  localparam int NW  = fgn_pkg::N_W;
  localparam int FB  = fgn_pkg::FRAC_BITS;
  localparam int AB  = fgn_pkg::ANGLE_BITS;

  logic [NS-1:0]      vld_r;
  fgn_pkg::oct_bus_t  bus_r [NS];
  fgn_pkg::oct_bus_t  bus0_nxt, busl_nxt;

  // S1
  logic [31:0] xmag, ymag, fnext;
  logic [47:0] fprod;
  logic [63:0] px_r, py_r;
  logic        negx_r, negy_r;
  // S2
  logic [63:0] pxs, pys;
  logic [31:0] cx_r, cy_r;
  logic [29:0] fx_r, fy_r;
  // S3
  logic [31:0] hx0_r, hx1_r, hy0_r, hy1_r, hs_r;
  logic [59:0] tsx, tsy;
  logic [29:0] tx2_r, ty2_r;
  logic [29:0] fxd_r [4];
  logic [29:0] fyd_r [4];
  // S4
  logic [31:0] m1_r [4];
  logic [29:0] tx3_r, ty3_r;
  logic [35:0] bx_r, by_r;
  logic [59:0] t3x, t3y;
  // S5
  logic [31:0] m2_r [4];
  logic [65:0] upx, upy;
  logic [30:0] u5_r, v5_r;
  logic [30:0] ud_r [3];
  logic [30:0] vd_r [4];
  // S6
  logic signed [16:0] gx_r [4];
  logic signed [16:0] gy_r [4];
  // S7
  logic signed [48:0] pgx_r [4];
  logic signed [48:0] pgy_r [4];
  // S8
  logic signed [NW-1:0] dot_r [4];
  // S9 .. S12
  logic signed [NW-1:0] nx0_r, nx1_r, n_r, ns_r, nsel_r;
  logic signed [NW:0]   d0, d1, d2;
  logic signed [68:0]   bp0, bp1, bp2;
  logic signed [67:0]   sp;
  logic [NW-1:0]        nmag, rm;
  logic signed [NW:0]   rt;
  logic [2*NW-1:0]      rmm;
  // S13
  logic signed [53:0]   wprod;
  logic [32:0]          aprod;

  assign out_valid = vld_r[NS-1];
  assign out_bus   = bus_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // ---- S1: magnitude times frequency, next octave frequency
  always_comb begin
    xmag  = in_bus.x[31] ? (~in_bus.x + 32'd1) : in_bus.x;
    ymag  = in_bus.y[31] ? (~in_bus.y + 32'd1) : in_bus.y;
    fprod = {16'd0, in_bus.freq} * {32'd0, cfg.lacunarity};
    fnext = (|fprod[47:44]) ? 32'hFFFF_FFFF : fprod[43:12];
    bus0_nxt      = in_bus;
    bus0_nxt.freq = fnext;
  end

  // ---- S2: restore sign, split cell and fraction
  always_comb begin
    pxs = negx_r ? (~px_r + 64'd1) : px_r;
    pys = negy_r ? (~py_r + 64'd1) : py_r;
  end

  // ---- S3/S4/S5 fade arithmetic
  always_comb begin
    tsx = {30'd0, fx_r} * {30'd0, fx_r};
    tsy = {30'd0, fy_r} * {30'd0, fy_r};
    t3x = {30'd0, tx2_r} * {30'd0, fxd_r[0]};
    t3y = {30'd0, ty2_r} * {30'd0, fyd_r[0]};
    upx = {36'd0, tx3_r} * {30'd0, bx_r};
    upy = {36'd0, ty3_r} * {30'd0, by_r};
  end

  // ---- S9 .. S12 blend, scale and ridge
  always_comb begin
    d0   = dot_r[1] - dot_r[0];
    d1   = dot_r[3] - dot_r[2];
    bp0  = d0 * $signed({1'b0, ud_r[2]});
    bp1  = d1 * $signed({1'b0, ud_r[2]});
    d2   = nx1_r - nx0_r;
    bp2  = d2 * $signed({1'b0, vd_r[3]});
    sp   = n_r * fgn_pkg::SQRT2_Q30;
    nmag = ns_r[NW-1] ? (~ns_r + 1'b1) : ns_r;
    rt   = $signed({(NW-30)'(0), fgn_pkg::ONE_Q30}) - $signed({1'b0, nmag});
    rm   = rt[NW] ? NW'(~rt + 1'b1) : NW'(rt);
    rmm  = {{NW{1'b0}}, rm} * {{NW{1'b0}}, rm};
  end

  // ---- S13: weighted accumulate, next amplitude
  always_comb begin
    wprod = $signed({1'b0, bus_r[NS-2].amp}) * nsel_r;
    aprod = {16'd0, bus_r[NS-2].amp} * {17'd0, cfg.gain};
    busl_nxt     = bus_r[NS-2];
    busl_nxt.amp = aprod[32:16];
    if (active) begin
      busl_nxt.sum  = bus_r[NS-2].sum
                    + {{(fgn_pkg::SUM_W-54){wprod[53]}}, wprod};
      busl_nxt.norm = bus_r[NS-2].norm
                    + {{(fgn_pkg::NORM_W-fgn_pkg::AMP_W){1'b0}}, bus_r[NS-2].amp};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bus_r[0] <= bus0_nxt;
      for (int i = 1; i < NS - 1; i++) begin
        bus_r[i] <= bus_r[i-1];
      end
      bus_r[NS-1] <= busl_nxt;

      // S1
      px_r   <= {32'd0, xmag} * {32'd0, in_bus.freq};
      py_r   <= {32'd0, ymag} * {32'd0, in_bus.freq};
      negx_r <= in_bus.x[31];
      negy_r <= in_bus.y[31];

      // S2
      cx_r <= pxs[63:32];
      cy_r <= pys[63:32];
      fx_r <= {pxs[31 -: FB], {(30-FB){1'b0}}};
      fy_r <= {pys[31 -: FB], {(30-FB){1'b0}}};

      // S3
      hx0_r <= cx_r * fgn_pkg::H_MX;
      hx1_r <= (cx_r + 32'd1) * fgn_pkg::H_MX;
      hy0_r <= cy_r * fgn_pkg::H_MY;
      hy1_r <= (cy_r + 32'd1) * fgn_pkg::H_MY;
      hs_r  <= cfg.seed * fgn_pkg::H_MS;
      tx2_r <= tsx[59:30];
      ty2_r <= tsy[59:30];
      fxd_r[0] <= fx_r;
      fyd_r[0] <= fy_r;
      for (int i = 1; i < 4; i++) begin
        fxd_r[i] <= fxd_r[i-1];
        fyd_r[i] <= fyd_r[i-1];
      end

      // S4
      for (int c = 0; c < 4; c++) begin
        m1_r[c] <= (((c % 2) != 0 ? hx1_r : hx0_r) ^ ((c / 2) != 0 ? hy1_r : hy0_r) ^ hs_r
                   ^ ((((c % 2) != 0 ? hx1_r : hx0_r) ^ ((c / 2) != 0 ? hy1_r : hy0_r)
                   ^ hs_r) >> 16)) * fgn_pkg::H_M1;
      end
      tx3_r <= t3x[59:30];
      ty3_r <= t3y[59:30];
      bx_r  <= ({6'd0, tx2_r} * 36'd6) + (36'd10 << 30) - ({6'd0, fxd_r[0]} * 36'd15);
      by_r  <= ({6'd0, ty2_r} * 36'd6) + (36'd10 << 30) - ({6'd0, fyd_r[0]} * 36'd15);

      // S5
      for (int c = 0; c < 4; c++) begin
        m2_r[c] <= (m1_r[c] ^ (m1_r[c] >> 15)) * fgn_pkg::H_M2;
      end
      u5_r <= upx[60:30];
      v5_r <= upy[60:30];

      // S6
      for (int c = 0; c < 4; c++) begin
        {gx_r[c], gy_r[c]} <=
          fgn_pkg::grad_vec(AB'((m2_r[c] ^ (m2_r[c] >> 16)) >> (32 - AB)));
      end
      ud_r[0] <= u5_r;
      vd_r[0] <= v5_r;
      for (int i = 1; i < 3; i++) ud_r[i] <= ud_r[i-1];
      for (int i = 1; i < 4; i++) vd_r[i] <= vd_r[i-1];

      // S7: offsets from each corner are frac or frac - 1
      for (int c = 0; c < 4; c++) begin
        pgx_r[c] <= gx_r[c] * ((c % 2) != 0
                    ? ($signed({2'b0, fxd_r[3]}) - 32'sh4000_0000)
                    : $signed({2'b0, fxd_r[3]}));
        pgy_r[c] <= gy_r[c] * ((c / 2) != 0
                    ? ($signed({2'b0, fyd_r[3]}) - 32'sh4000_0000)
                    : $signed({2'b0, fyd_r[3]}));
      end

      // S8
      for (int c = 0; c < 4; c++) begin
        dot_r[c] <= NW'(($signed({pgx_r[c][48], pgx_r[c]})
                       + $signed({pgy_r[c][48], pgy_r[c]})) >>> 15);
      end

      // S9, S10
      nx0_r <= dot_r[0] + NW'(bp0 >>> 30);
      nx1_r <= dot_r[2] + NW'(bp1 >>> 30);
      n_r   <= nx0_r + NW'(bp2 >>> 30);

      // S11
      ns_r  <= NW'(sp >>> 30);

      // S12
      nsel_r <= cfg.ridged_mode ? $signed(NW'(rmm >> 30)) : ns_r;
    end
  end

endmodule

FILE: rtl/fgn_div.sv
// ----------------------------------------------------------------------------
// fgn_div: normalise and round
// Signed sum over amplitude sum, one quotient bit per stage (restoring),
// truncated toward zero, then rounded to Q15 and saturated.
// ----------------------------------------------------------------------------
module fgn_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [fgn_pkg::SUM_W-1:0]  in_sum,
  input  logic [fgn_pkg::NORM_W-1:0]        in_norm,
  output logic                              out_valid,
  output logic signed [15:0]                out_value
);

  localparam int QW = fgn_pkg::Q_W;
  localparam int RW = fgn_pkg::RW;
  localparam int NW = fgn_pkg::NORM_W;

  logic [QW:0]         vld_r;
  logic [RW-1:0]       rem_r [QW+1];
  logic [QW-1:0]       q_r   [QW+1];
  logic [NW-1:0]       div_r [QW+1];
  logic                sgn_r [QW+1];
  logic [fgn_pkg::SUM_W-1:0] mag;
  logic signed [QW:0]  qs;
  logic signed [QW:0]  rnd;
  logic signed [15:0]  sat;
  logic                out_valid_r;
  logic signed [15:0]  out_value_r;

  assign mag = in_sum[fgn_pkg::SUM_W-1] ? (~in_sum + 1'b1) : in_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[QW-1:0], in_valid};
      out_valid_r <= vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= mag[RW-1:0];
      q_r[0]   <= '0;
      div_r[0] <= in_norm;
      sgn_r[0] <= in_sum[fgn_pkg::SUM_W-1];
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_step
    localparam int K = QW - i;
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = {{(RW-NW){1'b0}}, div_r[i-1]} << K;
    assign ge    = rem_r[i-1] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? (rem_r[i-1] - trial) : rem_r[i-1];
        q_r[i]   <= q_r[i-1] | (QW'(ge) << K);
        div_r[i] <= div_r[i-1];
        sgn_r[i] <= sgn_r[i-1];
      end
    end
  end

  // rounding and limits are signed compares
  always_comb begin
    qs  = sgn_r[QW] ? -$signed({1'b0, q_r[QW]}) : $signed({1'b0, q_r[QW]});
    rnd = (qs + $signed((QW+1)'(16384))) >>> 15;
    if (rnd > $signed((QW+1)'(32767))) begin
      sat = 16'sh7fff;
    end else if (rnd < -$signed((QW+1)'(32768))) begin
      sat = -16'sh8000;
    end else begin
      sat = rnd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule
